>>> design/snc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package snc_pkg;

    // default configuration of the top level
    localparam int MAX_TAPS_DEF    = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed field widths
    localparam int LEN_BITS   = 7;
    localparam int INDEX_BITS = 6;
    localparam int VALUE_BITS = 16;
    localparam int COEF_BITS  = 16;
    localparam int POS_BITS   = 32;

    // operands are brought below 2^NORM_BITS before the ratio stage
    localparam int NORM_BITS  = 37;
    localparam int MUL_STEPS  = NORM_BITS;
    localparam int DIV_STEPS  = 33;
    localparam int ROOT_STEPS = 16;
    localparam int STEP_BITS  = 6;

    // reset value of the length register
    localparam logic [LEN_BITS-1:0] LEN_RESET = 7'd64;

    // input kind carried in tuser bit 0
    localparam logic CMD_TAP    = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MAC   = 9'b000000010,
        ST_CHECK = 9'b000000100,
        ST_NORM  = 9'b000001000,
        ST_MUL   = 9'b000010000,
        ST_DIV   = 9'b000100000,
        ST_ROOT  = 9'b001000000,
        ST_FIN   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic tap_wr;
        logic sample_wr;
        logic mac_start;
        logic mac_run;
        logic norm_load;
        logic norm_shift;
        logic set_zero;
        logic set_null;
        logic mul_start;
        logic mul_run;
        logic div_start;
        logic div_run;
        logic root_start;
        logic root_run;
        logic finish;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic window_full;
        logic mac_done;
        logic acc_zero;
        logic norm_zero;
        logic too_big;
        logic step_done;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

>>> design/snc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module snc_ctrl
    import snc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  in_kind,
    input  wire stat_t stat,
    output logic       in_ready,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // sequencing of the phases
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_kind == CMD_TAP)
                    begin
                        cmd.tap_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.sample_wr = 1'b1;
                        if (stat.window_full)
                        begin
                            cmd.mac_start = 1'b1;
                            state_next    = ST_MAC;
                        end
                    end
                end
            end
            ST_MAC:
            begin
                cmd.mac_run = 1'b1;
                if (stat.mac_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.acc_zero)
                begin
                    cmd.set_zero = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.norm_load = 1'b1;
                    state_next    = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (stat.too_big)
                begin
                    cmd.norm_shift = 1'b1;
                end
                else if (stat.norm_zero)
                begin
                    cmd.set_null = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_run = 1'b1;
                if (stat.step_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cmd.div_start == 1'b0)
                begin
                    cmd.div_run = 1'b1;
                end
                if (stat.step_done)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                cmd.root_run = 1'b1;
                if (stat.step_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // each phase hands over to the next on its last step
        if (state_reg == ST_MUL && stat.step_done)
        begin
            cmd.div_start = 1'b1;
        end
        if (state_reg == ST_DIV && stat.step_done)
        begin
            cmd.root_start = 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> design/snc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module snc_datapath
    import snc_pkg::*;
#(
    parameter int MAX_TAPS    = MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output stat_t                      stat,
    input  wire logic                  cfg_wr_en,
    input  wire logic [LEN_BITS-1:0]   cfg_wr_data,
    input  wire logic [INDEX_BITS-1:0] in_index,
    input  wire logic [VALUE_BITS-1:0] in_value,
    input  wire logic                  in_first,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [COEF_BITS-1:0]       out_coef,
    output logic [POS_BITS-1:0]        out_pos,
    output logic                       out_zero
);

    localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int LW = $clog2(MAX_TAPS + 1);
    localparam int AW = 2 * SAMPLE_BITS + $clog2(MAX_TAPS);
    localparam int PW = 2 * NORM_BITS;
    localparam int RW = PW + 32;

    // storage
    logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] tmpl_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]           tval_reg;

    logic [LEN_BITS-1:0] len_cfg_reg;
    logic [IW-1:0]       wr_ptr_reg;
    logic [LW-1:0]       seen_reg;
    logic [POS_BITS-1:0] offset_reg;

    // window read
    logic [IW-1:0]                 rd_addr_reg;
    logic [LW-1:0]                 iss_reg;
    logic                          vld_reg;
    logic signed [SAMPLE_BITS-1:0] h_rd_reg;
    logic signed [SAMPLE_BITS-1:0] t_rd_reg;
    logic                          tv_rd_reg;

    // sums
    logic signed [AW:0] dot_reg;
    logic [AW-1:0]      ew_reg;
    logic [AW-1:0]      et_reg;
    logic [AW-1:0]      ewn_reg;
    logic [AW-1:0]      etn_reg;
    logic [AW-1:0]      dmn_reg;
    logic               neg_reg;

    // ratio stage
    logic [PW-1:0]        mca_reg;
    logic [PW-1:0]        mcb_reg;
    logic [NORM_BITS-1:0] mpa_reg;
    logic [NORM_BITS-1:0] mpb_reg;
    logic [PW-1:0]        pa_reg;
    logic [PW-1:0]        pb_reg;
    logic [RW-1:0]        rem_reg;
    logic [RW-1:0]        dsr_reg;
    logic [DIV_STEPS-1:0] qd_reg;
    logic [31:0]          sv_reg;
    logic [15:0]          root_reg;
    logic [15:0]          mask_reg;
    logic [STEP_BITS-1:0] step_reg;

    logic [COEF_BITS-1:0] res_coef_reg;
    logic                 res_zero_reg;
    logic                 m_valid_reg;
    logic [COEF_BITS-1:0] m_coef_reg;
    logic [POS_BITS-1:0]  m_pos_reg;
    logic                 m_zero_reg;

    // input decode
    logic signed [SAMPLE_BITS-1:0] in_val;
    logic                          tap_ok;
    logic [IW-1:0]                 tap_addr;

    assign in_val   = SAMPLE_BITS'(32'(in_value));
    assign tap_ok   = (32'(in_index) < MAX_TAPS);
    assign tap_addr = IW'(in_index);

    // effective length
    logic [LW-1:0] len_eff;

    always_comb
    begin
        if (len_cfg_reg == '0)
        begin
            len_eff = LW'(1);
        end
        else if (32'(len_cfg_reg) > MAX_TAPS)
        begin
            len_eff = LW'(MAX_TAPS);
        end
        else
        begin
            len_eff = LW'(len_cfg_reg);
        end
    end

    // fill count after this sample
    logic [LW-1:0] seen_next;

    always_comb
    begin
        if (in_first)
        begin
            seen_next = LW'(1);
        end
        else if (seen_reg == LW'(MAX_TAPS))
        begin
            seen_next = seen_reg;
        end
        else
        begin
            seen_next = seen_reg + LW'(1);
        end
    end

    // oldest window entry relative to the newest write
    logic [LW:0] sp_sum;
    logic [LW:0] sp_mod;
    logic [IW-1:0] start_ptr;
    logic [IW-1:0] wr_ptr_inc;
    logic [IW-1:0] rd_addr_inc;

    assign sp_sum     = (LW+1)'(wr_ptr_reg) + (LW+1)'(MAX_TAPS) - (LW+1)'(len_eff - LW'(1));
    assign sp_mod     = (sp_sum >= (LW+1)'(MAX_TAPS)) ? sp_sum - (LW+1)'(MAX_TAPS) : sp_sum;
    assign start_ptr  = IW'(sp_mod);
    assign wr_ptr_inc = (wr_ptr_reg == IW'(MAX_TAPS - 1)) ? '0 : wr_ptr_reg + IW'(1);
    assign rd_addr_inc = (rd_addr_reg == IW'(MAX_TAPS - 1)) ? '0 : rd_addr_reg + IW'(1);

    // products of one window position
    logic signed [SAMPLE_BITS-1:0]   t_eff;
    logic signed [2*SAMPLE_BITS-1:0] p_xt;
    logic signed [2*SAMPLE_BITS-1:0] p_xx;
    logic signed [2*SAMPLE_BITS-1:0] p_tt;

    assign t_eff = tv_rd_reg ? t_rd_reg : '0;
    assign p_xt  = h_rd_reg * t_eff;
    assign p_xx  = h_rd_reg * h_rd_reg;
    assign p_tt  = t_eff * t_eff;

    // root trial
    logic [15:0] trial;
    logic [31:0] trial_sq;
    logic [15:0] q_clip;

    assign trial    = root_reg | mask_reg;
    assign trial_sq = trial * trial;
    assign q_clip   = (root_reg > 16'd32768) ? 16'd32768 : root_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.sample_wr)
        begin
            hist_mem[wr_ptr_reg] <= in_val;
        end
        if (cmd.tap_wr && tap_ok)
        begin
            tmpl_mem[tap_addr] <= in_val;
        end
        if (cmd.mac_run && (iss_reg < len_eff))
        begin
            h_rd_reg  <= hist_mem[rd_addr_reg];
            t_rd_reg  <= tmpl_mem[iss_reg[IW-1:0]];
            tv_rd_reg <= tval_reg[iss_reg[IW-1:0]];
        end
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tval_reg    <= '0;
            len_cfg_reg <= LEN_RESET;
            wr_ptr_reg  <= '0;
            seen_reg    <= '0;
            offset_reg  <= '0;
            iss_reg     <= '0;
            vld_reg     <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                len_cfg_reg <= cfg_wr_data;
            end
            if (cmd.tap_wr && tap_ok)
            begin
                tval_reg[tap_addr] <= 1'b1;
            end
            if (cmd.sample_wr)
            begin
                wr_ptr_reg <= wr_ptr_inc;
                seen_reg   <= seen_next;
                if (in_first)
                begin
                    offset_reg <= '0;
                end
            end
            // window walk
            if (cmd.mac_start)
            begin
                iss_reg <= '0;
                vld_reg <= 1'b0;
            end
            else if (cmd.mac_run)
            begin
                if (iss_reg < len_eff)
                begin
                    iss_reg <= iss_reg + LW'(1);
                    vld_reg <= 1'b1;
                end
                else
                begin
                    vld_reg <= 1'b0;
                end
            end
            // step counter of the iterative phases, one spare step in the multiply and divide
            // phases so the last iteration has settled at hand-over
            if (cmd.mul_start)
            begin
                step_reg <= STEP_BITS'(MUL_STEPS);
            end
            else if (cmd.div_start)
            begin
                step_reg <= STEP_BITS'(DIV_STEPS);
            end
            else if (cmd.root_start)
            begin
                step_reg <= STEP_BITS'(ROOT_STEPS - 1);
            end
            else if ((cmd.mul_run || cmd.div_run || cmd.root_run) && step_reg != '0)
            begin
                step_reg <= step_reg - STEP_BITS'(1);
            end
            // output register
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
                if (offset_reg != '1)
                begin
                    offset_reg <= offset_reg + POS_BITS'(1);
                end
            end
            else if (out_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // arithmetic registers
    always_ff @(posedge clk)
    begin
        // accumulate
        if (cmd.mac_start)
        begin
            rd_addr_reg <= start_ptr;
            dot_reg     <= '0;
            ew_reg      <= '0;
            et_reg      <= '0;
        end
        else if (cmd.mac_run)
        begin
            if (iss_reg < len_eff)
            begin
                rd_addr_reg <= rd_addr_inc;
            end
            if (vld_reg)
            begin
                dot_reg <= dot_reg + (AW+1)'(p_xt);
                ew_reg  <= ew_reg + AW'($unsigned(p_xx));
                et_reg  <= et_reg + AW'($unsigned(p_tt));
            end
        end
        // common right shift of the three sums
        if (cmd.norm_load)
        begin
            ewn_reg <= ew_reg;
            etn_reg <= et_reg;
            dmn_reg <= dot_reg[AW] ? AW'(-dot_reg) : AW'(dot_reg);
            neg_reg <= dot_reg[AW];
        end
        else if (cmd.norm_shift)
        begin
            ewn_reg <= ewn_reg >> 1;
            etn_reg <= etn_reg >> 1;
            dmn_reg <= dmn_reg >> 1;
        end
        // shift-and-add products ew*et and dm*dm
        if (cmd.mul_start)
        begin
            mca_reg <= PW'(NORM_BITS'(etn_reg));
            mpa_reg <= NORM_BITS'(ewn_reg);
            mcb_reg <= PW'(NORM_BITS'(dmn_reg));
            mpb_reg <= NORM_BITS'(dmn_reg);
            pa_reg  <= '0;
            pb_reg  <= '0;
        end
        else if (cmd.mul_run)
        begin
            if (mpa_reg[0])
            begin
                pa_reg <= pa_reg + mca_reg;
            end
            if (mpb_reg[0])
            begin
                pb_reg <= pb_reg + mcb_reg;
            end
            mca_reg <= mca_reg << 1;
            mcb_reg <= mcb_reg << 1;
            mpa_reg <= mpa_reg >> 1;
            mpb_reg <= mpb_reg >> 1;
        end
        // restoring division of dm^2 * 2^30 by ew*et, top bit flags overflow
        if (cmd.div_start)
        begin
            rem_reg <= RW'({pb_reg, 30'b0});
            dsr_reg <= {pa_reg, 32'b0};
            qd_reg  <= '0;
        end
        else if (cmd.div_run && step_reg != '0)
        begin
            if (rem_reg >= dsr_reg)
            begin
                rem_reg <= rem_reg - dsr_reg;
                qd_reg  <= {qd_reg[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                qd_reg  <= {qd_reg[DIV_STEPS-2:0], 1'b0};
            end
            dsr_reg <= dsr_reg >> 1;
        end
        // integer square root, one bit a step
        if (cmd.root_start)
        begin
            sv_reg   <= qd_reg[DIV_STEPS-1] ? '1 : qd_reg[31:0];
            root_reg <= '0;
            mask_reg <= 16'h8000;
        end
        else if (cmd.root_run)
        begin
            if (trial_sq <= sv_reg)
            begin
                root_reg <= trial;
            end
            mask_reg <= mask_reg >> 1;
        end
        // result
        if (cmd.set_zero)
        begin
            res_coef_reg <= '0;
            res_zero_reg <= 1'b1;
        end
        else if (cmd.set_null)
        begin
            res_coef_reg <= '0;
            res_zero_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            res_zero_reg <= 1'b0;
            if (neg_reg)
            begin
                res_coef_reg <= COEF_BITS'(~q_clip + 16'd1);
            end
            else
            begin
                res_coef_reg <= (q_clip > 16'd32767) ? 16'd32767 : q_clip;
            end
        end
        if (cmd.out_load)
        begin
            m_coef_reg <= res_coef_reg;
            m_pos_reg  <= offset_reg;
            m_zero_reg <= res_zero_reg;
        end
    end

    // status
    always_comb
    begin
        stat             = '0;
        stat.window_full = (seen_next >= len_eff);
        stat.mac_done    = (iss_reg == len_eff) && !vld_reg;
        stat.acc_zero    = (ew_reg == '0) || (et_reg == '0);
        stat.norm_zero   = (ewn_reg == '0) || (etn_reg == '0);
        stat.too_big     = ((ewn_reg >> NORM_BITS) != '0) || ((etn_reg >> NORM_BITS) != '0)
                         || ((dmn_reg >> NORM_BITS) != '0);
        stat.step_done   = (step_reg == '0);
        stat.out_free    = !m_valid_reg || out_ready;
    end

    assign out_valid = m_valid_reg;
    assign out_coef  = m_coef_reg;
    assign out_pos   = m_pos_reg;
    assign out_zero  = m_zero_reg;

endmodule

`default_nettype wire

>>> design/sliding_normalized_correlation.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: tap_index, value; tuser: command, first
// m_*       out  m_tvalid/m_tready  tdata: coefficient, position; tuser: zero_energy
// cfg_*     in   cfg_wr_en          cfg_wr_data: template_length
//
// a tap load or a sample that does not fill the window leaves s_tready high for the next request
// a full-window sample keeps s_tready low while the window walk reads one tap a cycle,
// then the 38 shift-add, the divide and the 16 root steps run (plus norm shifts)
// rst_n is asynchronous: template taps read as zero until written, history is empty
// a finished result waits in the output register while the next request is taken

module sliding_normalized_correlation
    import snc_pkg::*;
#(
    parameter int MAX_TAPS    = MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [23:0]         s_tdata,     // tap_index[5:0], value[21:6], zero pad
    input  wire logic [1:0]          s_tuser,     // command[0], first[1]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [47:0]              m_tdata,     // coefficient[15:0], position[47:16]
    output logic [0:0]               m_tuser,     // zero_energy[0]
    input  wire logic                cfg_wr_en,
    input  wire logic [LEN_BITS-1:0] cfg_wr_data
);

    cmd_t  cmd;
    stat_t stat;

    logic [COEF_BITS-1:0] coef;
    logic [POS_BITS-1:0]  pos;
    logic                 zero;

    // sequencer
    snc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser[0]),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    // storage and arithmetic
    snc_datapath #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_index    (s_tdata[5:0]),
        .in_value    (s_tdata[21:6]),
        .in_first    (s_tuser[1]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_coef    (coef),
        .out_pos     (pos),
        .out_zero    (zero)
    );

    // result packing
    assign m_tdata = {pos, coef};
    assign m_tuser = zero;

endmodule

`default_nettype wire

>>> design/snc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module snc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a tap load never blocks the next request
    a_tap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser[0] |=> s_tready)
        else $error("tap load stalled input");

    // zero energy forces a zero coefficient
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[15:0] == 16'd0)
        else $error("zero energy with nonzero coefficient");

    // a new result only appears after a busy cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result without computation");

endmodule

bind sliding_normalized_correlation snc_checker u_snc_checker (.*);

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import snc_pkg::*;

    // one expected result
    typedef struct packed {
        logic signed [COEF_BITS-1:0] coef;
        logic [POS_BITS-1:0]         pos;
        logic                        zero_energy;
    } corr_result_t;

    // predicts coefficients and holds those not yet seen on the output
    class correlation_tracker;
        logic signed [VALUE_BITS-1:0] taps [MAX_TAPS_DEF];
        logic signed [VALUE_BITS-1:0] history [MAX_TAPS_DEF];  // index 0 is newest
        int unsigned                  seen;
        logic [POS_BITS-1:0]          offset;
        logic [LEN_BITS-1:0]          length_reg;
        corr_result_t                 pending_results [$];
        int                           errors;

        function new();
            for (int i = 0; i < MAX_TAPS_DEF; i++)
            begin
                taps[i]    = '0;
                history[i] = '0;
            end
            seen       = 0;
            offset     = '0;
            length_reg = LEN_RESET;
            errors     = 0;
        endfunction

        function void set_length(logic [LEN_BITS-1:0] v);
            length_reg = v;
        endfunction

        // note one accepted request and queue the result it causes, if any
        function void take_request(logic cmd, logic [INDEX_BITS-1:0] idx,
                                   logic signed [VALUE_BITS-1:0] v, logic first);
            int           len;
            longint       dot, x, t;
            longint       ew, et, dm, big;
            int           sh;
            bit [127:0]   lhs, rhs, qq, e1, e2, d1;
            bit [16:0]    q, trial;
            corr_result_t r;
            if (cmd == CMD_TAP)
            begin
                taps[idx] = v;
                return;
            end
            if (first)
            begin
                for (int i = 0; i < MAX_TAPS_DEF; i++)
                    history[i] = '0;
                seen   = 0;
                offset = '0;
            end
            for (int i = MAX_TAPS_DEF - 1; i > 0; i--)
                history[i] = history[i-1];
            history[0] = v;
            if (seen < MAX_TAPS_DEF)
                seen++;
            len = length_reg;
            if (len < 1)
                len = 1;
            if (len > MAX_TAPS_DEF)
                len = MAX_TAPS_DEF;
            if (seen < len)
                return;
            dot = 0;
            ew  = 0;
            et  = 0;
            for (int j = 0; j < len; j++)
            begin
                x = history[len-1-j];
                t = taps[j];
                dot += x * t;
                ew  += x * x;
                et  += t * t;
            end
            r.pos         = offset;
            r.zero_energy = 1'b0;
            r.coef        = '0;
            if (ew == 0 || et == 0)
                r.zero_energy = 1'b1;
            else
            begin
                dm  = dot < 0 ? -dot : dot;
                big = ew;
                if (et > big)
                    big = et;
                if (dm > big)
                    big = dm;
                sh = 0;
                while ((big >>> sh) >= (64'd1 << NORM_BITS))
                    sh++;
                ew = ew >>> sh;
                et = et >>> sh;
                dm = dm >>> sh;
                if (ew != 0 && et != 0)
                begin
                    // largest q with q^2 * ew * et <= dm^2 * 2^30
                    q  = '0;
                    e1 = ew;
                    e2 = et;
                    d1 = dm;
                    rhs = (d1 * d1) << 30;
                    for (int b = 15; b >= 0; b--)
                    begin
                        trial = q | (17'd1 << b);
                        qq    = trial;
                        lhs   = qq * qq * e1 * e2;
                        if (lhs <= rhs)
                            q = trial;
                    end
                    if (q > 32768)
                        q = 17'd32768;
                    if (dot < 0)
                        r.coef = -$signed({1'b0, q[15:0]});
                    else
                        r.coef = (q > 32767) ? 16'sd32767 : q[15:0];
                end
            end
            pending_results.push_back(r);
            if (offset != '1)
                offset++;
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_result(logic [COEF_BITS-1:0] coef, logic [POS_BITS-1:0] pos,
                                   logic ze);
            corr_result_t e;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result coef %0d pos %0d zero %0d",
                         $time, $signed(coef), pos, ze);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (e.coef !== coef)
            begin
                $display("%0t: coefficient expected %0d actual %0d", $time, e.coef,
                         $signed(coef));
                errors++;
            end
            if (e.pos !== pos)
            begin
                $display("%0t: position expected %0d actual %0d", $time, e.pos, pos);
                errors++;
            end
            if (e.zero_energy !== ze)
            begin
                $display("%0t: zero_energy expected %0d actual %0d", $time,
                         e.zero_energy, ze);
                errors++;
            end
        endfunction
    endclass

    localparam int IDLE_CYCLES = 300;
    localparam int STALL_LIMIT = 20000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [23:0]         s_tdata;
    logic [1:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [47:0]         m_tdata;
    logic [0:0]          m_tuser;
    logic                cfg_wr_en;
    logic [LEN_BITS-1:0] cfg_wr_data;

    correlation_tracker tracker;
    logic               hold_req;
    bit                 no_gaps;
    int                 quiet_cycles;

    sliding_normalized_correlation dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 clk = ~clk;

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    // offer one request and wait for it to be taken
    task automatic send_request(logic cmd, logic [5:0] idx, logic [15:0] v, logic first);
        int g;
        g = no_gaps ? 0 : pick_gap();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, v, idx};
        s_tuser  <= {first, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.take_request(cmd, idx, v, first);
    endtask

    // wait for all results, let the block settle, then write the length
    task automatic write_length(logic [LEN_BITS-1:0] v);
        s_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        tracker.set_length(v);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'h8000;
        if (r == 1)
            return 16'h7fff;
        if (r < 4)
            return 16'h0000;
        return $urandom_range(0, 65535);
    endfunction

    // result side: random ready, occasional long stalls, one forced hold-off
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata[15:0], m_tdata[47:16], m_tuser[0]);
            if (hold_req)
            begin
                stall = 4000;
                hold_req <= 1'b0;
            end
            else if (stall == 0 && $urandom_range(0, 199) == 0)
                stall = $urandom_range(30, 300);
            if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [LEN_BITS-1:0] lengths [12];
        int                  n;
        tracker      = new();
        quiet_cycles = 0;
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= '0;
        m_tready     <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        hold_req     <= 1'b0;
        no_gaps      = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: length 0 acts as one tap, clamp and zero energy
        write_length(7'd0);
        send_request(CMD_TAP, 6'd0, 16'h7fff, 1'b0);
        send_request(CMD_SAMPLE, 6'd0, 16'h8000, 1'b1);
        send_request(CMD_SAMPLE, 6'd63, 16'h7fff, 1'b0);
        send_request(CMD_SAMPLE, 6'd0, 16'h0000, 1'b0);
        send_request(CMD_TAP, 6'd0, 16'h8000, 1'b0);
        send_request(CMD_SAMPLE, 6'd0, 16'h8000, 1'b0);
        send_request(CMD_SAMPLE, 6'd0, 16'h7fff, 1'b0);
        // two taps, restart mid-signal, top tap index
        write_length(7'd2);
        send_request(CMD_TAP, 6'd1, 16'h0001, 1'b0);
        send_request(CMD_TAP, 6'd63, 16'hffff, 1'b0);
        send_request(CMD_SAMPLE, 6'd0, 16'h1234, 1'b1);
        send_request(CMD_SAMPLE, 6'd0, 16'hedcc, 1'b0);
        send_request(CMD_SAMPLE, 6'd0, 16'h0001, 1'b1);
        send_request(CMD_SAMPLE, 6'd0, 16'h0000, 1'b0);
        send_request(CMD_SAMPLE, 6'd0, 16'h0000, 1'b0);
        // above the tap count acts as the maximum
        write_length(7'd127);
        send_request(CMD_SAMPLE, 6'd0, 16'h7fff, 1'b1);

        // random phases over several lengths, extremes among them
        lengths = '{7'd64, 7'd1, 7'd127, 7'd3, 7'd0, 7'd64, 7'd8, 7'd2, 7'd65,
                    7'd5, 7'd16, 7'd1};
        for (int p = 0; p < 12; p++)
        begin
            write_length(p == 0 ? 7'd64 : (p == 11 ? $urandom_range(0, 127) : lengths[p]));
            no_gaps = (p == 4 || p == 9);
            if (p == 2)
                hold_req <= 1'b1;
            n = 0;
            while (n < 165)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_request(CMD_TAP, $urandom_range(0, 63), pick_value(), 1'b0);
                else
                    send_request(CMD_SAMPLE, $urandom_range(0, 63), pick_value(),
                                 ($urandom_range(0, 39) == 0));
                n++;
            end
        end

        // drain
        s_tvalid <= 1'b0;
        no_gaps  = 0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
